/* rtl/positional_list_insert_delete_macros.svh */
// Assertion macros used by the positional list RTL.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define PLD_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PLD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/pld_pkg.sv */
// Package with the sizes, codes and types of the positional list.
package pld_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 2;
  localparam int ECNT_W   = 9;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CCMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Selection tree shape: leaves are gathered in groups of GRP per first stage.
  localparam int GRP    = 16;
  localparam int GROUPS = (CAPACITY + GRP - 1) / GRP;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic [1:0]        op;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } cell_ctl_t;

endpackage

/* rtl/pld_cell.sv */
// One storage cell of the list: holds an entry and shifts with its neighbors.
module pld_cell (
  input  logic                        clk,
  input  pld_pkg::cell_ctl_t          ctl,
  input  logic [pld_pkg::CMP_W-1:0]   idx,
  input  logic [pld_pkg::DATA_W-1:0]  left,
  input  logic [pld_pkg::DATA_W-1:0]  right,
  output logic [pld_pkg::DATA_W-1:0]  data,
  output logic [pld_pkg::DATA_W-1:0]  hit
);
  import pld_pkg::*;

  logic match;
  logic above;

  assign match = (idx == ctl.pos);
  assign above = (idx > ctl.pos);

  // The entry shows on the selection tree only in the cell at the position.
  assign hit = data & {DATA_W{match}};

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INS: begin
        if (above) begin
          data <= left;
        end else if (match) begin
          data <= ctl.val;
        end
      end
      OP_DEL: begin
        if (above || match) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/pld_orq.sv */
// Two-stage registered OR tree that picks out the one selected cell entry.
module pld_orq (
  input  logic                        clk,
  input  logic [pld_pkg::DATA_W-1:0]  leaf [pld_pkg::CAPACITY],
  output logic [pld_pkg::DATA_W-1:0]  sel
);
  import pld_pkg::*;

  logic [DATA_W-1:0] grp      [GROUPS];
  logic [DATA_W-1:0] grp_next [GROUPS];
  logic [DATA_W-1:0] sel_next;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | leaf[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    sel_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sel_next = sel_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
    sel <= sel_next;
  end

endmodule

/* rtl/positional_list_insert_delete.sv */
// Top level of the positional list: control, count and the row of cells.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  request   | in        | start, taken when !busy | cmd, position, new_value
//  result    | out       | done, one-cycle strobe  | out_value, entry_count, status
//
// A request is taken at a rising edge. The registered OR tree then reads the
// entry at the position out of the row of cells through its group and final
// registers; in the last cycle of the request the bounds are checked and every
// cell shifts at once, and the result strobe follows. busy falls as the strobe
// rises, so the next request can be taken at the edge that ends the strobe
// cycle; no new request is taken while one is in progress.
// Reset (rst, synchronous, active high) clears the count and the control
// state; the entries themselves are not cleared. The receiver of results
// cannot stall, so busy depends only on the request in progress.
module positional_list_insert_delete (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pld_pkg::CMD_W-1:0]         cmd,
  input  logic [pld_pkg::POS_W-1:0]         position,
  input  logic signed [pld_pkg::DATA_W-1:0] new_value,
  output logic                              done,
  output logic signed [pld_pkg::DATA_W-1:0] out_value,
  output logic [pld_pkg::ECNT_W-1:0]        entry_count,
  output logic [pld_pkg::ST_W-1:0]          status
);
  import pld_pkg::*;
  `include "positional_list_insert_delete_macros.svh"

  localparam logic [1:0] PH_LAST = 2'd2;

  // Request registers, loaded when a request is taken.
  logic [CMD_W-1:0]  cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;

  logic [1:0]        ph;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] res_next;
  logic [ST_W-1:0]   st;
  logic [ST_W-1:0]   st_next;
  logic [1:0]        op_next;
  logic              last;

  logic [CCMP_W-1:0] pos_c;
  logic [CCMP_W-1:0] count_c;

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_hit  [CAPACITY];
  logic [DATA_W-1:0] rd;

  assign last    = busy && (ph == PH_LAST);
  assign pos_c   = CCMP_W'(pos_q);
  assign count_c = CCMP_W'(count);

  // Bounds checks and the new count. A full list is reported before a bad
  // position; an unused command is treated as a bad position.
  always_comb begin
    op_next    = OP_HOLD;
    st_next    = ST_OK;
    res_next   = '0;
    count_next = count;
    case (cmd_q)
      CMD_INSERT: begin
        if (count >= CNT_W'(CAPACITY)) begin
          st_next = ST_FULL;
        end else if (pos_c > count_c) begin
          st_next = ST_RANGE;
        end else begin
          op_next    = OP_INS;
          count_next = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_c >= count_c) begin
          st_next = ST_RANGE;
        end else begin
          op_next    = OP_DEL;
          res_next   = rd;
          count_next = count - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_c >= count_c) begin
          st_next = ST_RANGE;
        end else begin
          res_next = rd;
        end
      end
      default: begin
        st_next = ST_RANGE;
      end
    endcase
  end

  // The cells shift only in the last cycle of a request; the position is held
  // all along so the read-out tree sees the entry before any shift.
  always_comb begin
    ctl.op  = last ? op_next : OP_HOLD;
    ctl.pos = CMP_W'(pos_q);
    ctl.val = val_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      ph    <= '0;
      count <= '0;
    end else begin
      done <= last;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          ph   <= '0;
        end
      end else if (last) begin
        busy  <= 1'b0;
        count <= count_next;
      end else begin
        ph <= ph + 1'b1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
      pos_q <= position;
      val_q <= new_value;
    end
    if (last) begin
      res <= res_next;
      st  <= st_next;
    end
  end

  assign out_value   = $signed(res);
  assign entry_count = ECNT_W'(count);
  assign status      = st;

  // The row of cells. Each cell sees its lower neighbor for an insert and its
  // upper neighbor for a delete; the ends take zero, which is never kept.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end
    pld_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (CMP_W'(i)),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .hit   (cell_hit[i])
    );
  end

  pld_orq u_orq (
    .clk  (clk),
    .leaf (cell_hit),
    .sel  (rd)
  );

  `PLD_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while a request is still busy")
  `PLD_ASSERT_NEXT(a_take_busy, start && !busy, busy && !done, "taken request did not go busy")
  `PLD_ASSERT_IMP(a_count_cap, done, count <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `PLD_ASSERT_IMP(a_err_zero, done && (status != ST_OK), out_value == '0, "error result carries a value")

endmodule

/* verif/tb_positional_list_insert_delete.sv */
// Self-checking testbench for the positional list with insert, delete and read requests.
module tb_positional_list_insert_delete;
  import pld_pkg::*;

  // The command field has a fourth code that the block must answer as out of range.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Longest stretch of cycles with neither a request taken nor a result seen.
  // The longest sender gap and the run of a single request are both far shorter, so this
  // leaves a wide margin while still catching a hung block quickly.
  localparam int unsigned STALL_LIMIT = 1000;

  // Rough number of requests for the random part.
  localparam int unsigned REQUEST_GOAL = 1650;

  // Cycles to keep watching for stray strobes once nothing is outstanding.
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [ECNT_W-1:0]        entries;
    logic [ST_W-1:0]          st;
  } list_result_t;

  // Keeps a shadow copy of the list, works out the answer to every request the
  // block takes and holds those answers until the matching strobe arrives.
  class list_mirror;
    logic signed [DATA_W-1:0] shadow_list[$];
    list_result_t             pending_results[$];
    int unsigned              mismatches;

    function int unsigned depth();
      return shadow_list.size();
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void note_request(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t r;
      int unsigned  n;
      n       = shadow_list.size();
      r.value = '0;
      r.st    = ST_OK;
      case (op)
        CMD_INSERT: begin
          // A full list is reported before the position is looked at.
          if (n >= CAPACITY) r.st = ST_FULL;
          else if (pos > n) r.st = ST_RANGE;
          else shadow_list.insert(pos, val);
        end
        CMD_DELETE: begin
          if (pos >= n) begin
            r.st = ST_RANGE;
          end else begin
            r.value = shadow_list[pos];
            shadow_list.delete(pos);
          end
        end
        CMD_READ: begin
          if (pos >= n) r.st = ST_RANGE;
          else r.value = shadow_list[pos];
        end
        default: r.st = ST_RANGE;
      endcase
      r.entries = ECNT_W'(shadow_list.size());
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, logic [ECNT_W-1:0] entries,
                               logic [ST_W-1:0] st);
      list_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (value !== exp.value) begin
        $error("out_value: expected %0d, got %0d", exp.value, value);
        mismatches++;
      end
      if (entries !== exp.entries) begin
        $error("entry_count: expected %0d, got %0d", exp.entries, entries);
        mismatches++;
      end
      if (st !== exp.st) begin
        $error("status: expected %0d, got %0d", exp.st, st);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         cmd;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] new_value;
  logic                     done;
  logic signed [DATA_W-1:0] out_value;
  logic [ECNT_W-1:0]        entry_count;
  logic [ST_W-1:0]          status;

  list_mirror  mirror;
  int unsigned requests_sent;
  int unsigned stall_cycles;
  // When set, the sender issues requests back to back with no idle cycles.
  bit          no_gaps;

  positional_list_insert_delete u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .position    (position),
    .new_value   (new_value),
    .done        (done),
    .out_value   (out_value),
    .entry_count (entry_count),
    .status      (status)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before a request: mostly none or a few, now and then a long
  // pause so that the block sits idle for a while between requests.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values lean toward the signed extremes, zero and minus one.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Puts one request on the inputs and holds it until the block takes it. The
  // request is accepted at the first rising edge where start is high and busy
  // is low; busy is read right after the edge, before the block updates it, so
  // the value seen is the one that edge sampled. start stays high across
  // back-to-back requests and is only lowered when a gap is wanted.
  task automatic send_request(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= op;
    position  <= pos;
    new_value <= val;
    do @(posedge clk); while (busy);
    mirror.note_request(op, pos, val);
    requests_sent++;
  endtask

  // Builds the list up to capacity with inserts at random places, pokes at the
  // full list, then takes it apart again with deletes, mixed with reads, at random places.
  task automatic run_fill_drain();
    int unsigned n;
    while (mirror.depth() < CAPACITY) begin
      n = mirror.depth();
      // A quarter of the inserts are made to append, which is how a list is normally loaded.
      if ($urandom_range(0, 3) == 0) send_request(CMD_INSERT, POS_W'(n), pick_value());
      else send_request(CMD_INSERT, POS_W'($urandom_range(0, n)), pick_value());
    end
    // Full list: every insert must be refused, wherever it points.
    send_request(CMD_INSERT, '0, pick_value());
    send_request(CMD_INSERT, '1, pick_value());
    send_request(CMD_INSERT, POS_W'($urandom), pick_value());
    // The highest position is a real entry only while the list is full.
    send_request(CMD_READ, '1, pick_value());
    send_request(CMD_READ, '0, pick_value());
    send_request(CMD_DELETE, '1, pick_value());
    send_request(CMD_READ, '1, pick_value());
    send_request(CMD_INSERT, '1, pick_value());
    send_request(CMD_UNUSED, '1, pick_value());
    while (mirror.depth() > 0) begin
      n = mirror.depth();
      if ($urandom_range(0, 4) == 0) send_request(CMD_READ, POS_W'($urandom_range(0, n - 1)),
                                                  pick_value());
      else send_request(CMD_DELETE, POS_W'($urandom_range(0, n - 1)), pick_value());
    end
  endtask

  // A run of mixed requests. Most point at valid places in the list; a few
  // point past its end and a few are pure noise, the unused code among them.
  // ins_pct steers whether the list tends to grow or shrink.
  task automatic run_churn(int unsigned len, int unsigned ins_pct);
    int unsigned      n;
    int unsigned      r;
    logic [CMD_W-1:0] op;
    for (int unsigned i = 0; i < len; i++) begin
      n = mirror.depth();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_request(CMD_W'($urandom_range(0, 3)), POS_W'($urandom), pick_value());
      end else if (r < 10) begin
        op = CMD_W'($urandom_range(0, 2));
        if (op == CMD_INSERT && n < 255)
          send_request(op, POS_W'($urandom_range(n + 1, 255)), pick_value());
        else if (op != CMD_INSERT && n <= 255)
          send_request(op, POS_W'($urandom_range(n, 255)), pick_value());
        else
          send_request(op, POS_W'($urandom), pick_value());
      end else if (r < 10 + ins_pct) begin
        if (n < CAPACITY) send_request(CMD_INSERT, POS_W'($urandom_range(0, n)), pick_value());
        else send_request(CMD_INSERT, POS_W'($urandom), pick_value());
      end else begin
        op = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_DELETE;
        if (n > 0) send_request(op, POS_W'($urandom_range(0, n - 1)), pick_value());
        else send_request(op, POS_W'($urandom), pick_value());
      end
    end
  endtask

  // Results are strobed for one cycle and cannot be held off, so they are
  // sampled on every rising edge where done is high.
  always @(posedge clk) begin
    if (!rst && done) mirror.check_result(out_value, entry_count, status);
  end

  // Watchdog: any cycle that moves a request or a result restarts the count.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_positional_list_insert_delete NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned ins_pct;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = CMD_INSERT;
    position      = '0;
    new_value     = '0;
    no_gaps       = 1'b0;
    requests_sent = 0;
    mirror        = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. On an empty list every read and delete is out of range,
    // and an insert may only go to position zero.
    send_request(CMD_READ, '0, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_UNUSED, '0, '0);
    send_request(CMD_INSERT, 8'd1, 32'sd7);
    // Load a short list with the signed extremes, then insert at the front
    // and in the middle so that entries have to shift.
    send_request(CMD_INSERT, '0, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(CMD_INSERT, 8'd1, {1'b0, {(DATA_W-1){1'b1}}});
    send_request(CMD_INSERT, '0, '1);
    send_request(CMD_INSERT, 8'd1, '0);
    send_request(CMD_READ, '0, '0);
    send_request(CMD_READ, 8'd3, '0);
    // A position equal to the count is one past the last entry.
    send_request(CMD_READ, 8'd4, '0);
    send_request(CMD_READ, '1, '0);
    send_request(CMD_DELETE, 8'd1, '0);
    send_request(CMD_DELETE, 8'd2, '0);
    send_request(CMD_DELETE, 8'd5, '0);
    send_request(CMD_INSERT, '1, 32'sd1);
    send_request(CMD_UNUSED, '1, {1'b0, {(DATA_W-1){1'b1}}});
    send_request(CMD_INSERT, 8'd2, 32'h5555_5555);
    send_request(CMD_INSERT, '0, 32'hAAAA_AAAA);
    send_request(CMD_READ, 8'd3, '0);
    send_request(CMD_DELETE, '0, '1);
    send_request(CMD_READ, '0, '0);

    // Random part. Reaching a full list takes a long well-formed run of
    // inserts, so it opens with one complete fill and drain; after that, short
    // mixed runs with changing growth bias, and now and then another fill.
    run_fill_drain();
    while (requests_sent < REQUEST_GOAL) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0 && requests_sent < REQUEST_GOAL - 550) begin
        run_fill_drain();
      end else begin
        case ($urandom_range(0, 2))
          0: ins_pct = 30;
          1: ins_pct = 45;
          default: ins_pct = 60;
        endcase
        run_churn($urandom_range(10, 60), ins_pct);
      end
    end
    start <= 1'b0;

    // Wait for every outstanding answer, then keep watching for any
    // stray strobe; the watchdog bounds both waits.
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("tb_positional_list_insert_delete OK");
    end else begin
      $display("tb_positional_list_insert_delete NOT OK");
    end
    $finish;
  end

endmodule
